[rtl/mgd_pkg.sv]
// Shared constants and types for the marker grid decoder.
// Geometry of the marker grid, register indexes, failure codes and the
// record passed from the cell accumulator to the orientation stage.
`timescale 1ns / 1ps

package mgd_pkg;

    // Marker geometry
    localparam int CELL_SIZE  = 10;            // pixels along one cell edge
    localparam int CELL_COUNT = 5;             // inner cells along one edge
    localparam int GRID_CELLS = CELL_COUNT + 2; // cells along one edge, border included

    localparam int CELL_W = $clog2(CELL_SIZE);  // pixel position inside a cell
    localparam int GRID_W = $clog2(GRID_CELLS); // cell position inside the grid

    // Cell counters and code word
    localparam int          COUNT_W     = 7;
    localparam logic [6:0]  COUNT_MAX   = 7'd127;
    localparam int          CODE_BITS   = 25;
    localparam int          CODE_STRIDE = 5;    // code bit index is row*5+col
    localparam int          IDX_W       = $clog2(CODE_BITS);

    // Configuration register indexes
    localparam logic REG_BORDER_LIMIT = 1'b0;
    localparam logic REG_BIT_LIMIT    = 1'b1;

    localparam logic [6:0] BORDER_LIMIT_RST = 7'd25;
    localparam logic [6:0] BIT_LIMIT_RST    = 7'd50;

    // Failure codes
    localparam logic [1:0] FAIL_NONE    = 2'd0;
    localparam logic [1:0] FAIL_BORDER  = 2'd1;
    localparam logic [1:0] FAIL_PATTERN = 2'd2;

    // Cell thresholds from the configuration registers
    typedef struct packed {
        logic [COUNT_W-1:0] border_limit;
        logic [COUNT_W-1:0] bit_limit;
    } t_limits;

    // Finished image, waiting for the orientation stage
    typedef struct packed {
        logic                 valid;
        logic                 border_failed;
        logic [CODE_BITS-1:0] bits;
    } t_done;

endpackage

[rtl/mgd_cell_accum.sv]
// Per-pixel cell accumulation: raster position, cell counters, cell judgement.
// Depends on mgd_pkg; hands each finished image to the orientation stage in
// a one-entry holding register.
`timescale 1ns / 1ps

module mgd_cell_accum
    import mgd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_accept,       // pixel transaction taken this cycle
    input  logic    i_pixel,
    input  logic    i_frame_start,
    input  t_limits i_limits,
    input  logic    i_take,         // orientation stage takes the held image
    output t_done   o_done
);

    // Raster position, split into cell and pixel-in-cell parts
    logic [CELL_W-1:0]  r_col_in_cell, n_col_in_cell;
    logic [GRID_W-1:0]  r_cell_col,    n_cell_col;
    logic [CELL_W-1:0]  r_row_in_cell, n_row_in_cell;
    logic [GRID_W-1:0]  r_cell_row,    n_cell_row;

    logic [COUNT_W-1:0] r_counts [GRID_CELLS];
    logic [COUNT_W-1:0] n_counts [GRID_CELLS];
    logic               r_border_failed, n_border_failed;
    logic [CODE_BITS-1:0] r_bits, n_bits;

    t_done r_done, n_done;

    // Pixel step
    always_comb begin
        logic [CELL_W-1:0]    v_cic, v_ric;
        logic [GRID_W-1:0]    v_cc, v_cr;
        logic [COUNT_W-1:0]   v_cnt;
        logic                 v_bf;
        logic [CODE_BITS-1:0] v_bits;
        logic                 v_cell_end, v_last, v_border;
        logic [IDX_W-1:0]     v_idx;

        // A frame start drops any partial image
        v_cic  = i_frame_start ? '0 : r_col_in_cell;
        v_cc   = i_frame_start ? '0 : r_cell_col;
        v_ric  = i_frame_start ? '0 : r_row_in_cell;
        v_cr   = i_frame_start ? '0 : r_cell_row;
        v_bf   = i_frame_start ? 1'b0 : r_border_failed;
        v_bits = i_frame_start ? '0 : r_bits;
        for (int i = 0; i < GRID_CELLS; i++) begin
            n_counts[i] = i_frame_start ? '0 : r_counts[i];
        end

        // Saturating count of set pixels in the current cell
        v_cnt = n_counts[v_cc];
        if (i_pixel && (v_cnt < COUNT_MAX)) begin
            v_cnt = v_cnt + COUNT_W'(1);
        end

        v_cell_end = (v_cic == CELL_W'(CELL_SIZE - 1)) && (v_ric == CELL_W'(CELL_SIZE - 1));
        v_last     = v_cell_end && (v_cc == GRID_W'(GRID_CELLS - 1))
                                && (v_cr == GRID_W'(GRID_CELLS - 1));
        v_border   = (v_cr == '0) || (v_cr == GRID_W'(GRID_CELLS - 1))
                  || (v_cc == '0) || (v_cc == GRID_W'(GRID_CELLS - 1));
        v_idx      = IDX_W'(IDX_W'(v_cr) - IDX_W'(1)) * IDX_W'(CODE_STRIDE)
                   + IDX_W'(v_cc) - IDX_W'(1);

        // Judge a completed cell and restart its counter
        if (v_cell_end) begin
            if (v_border) begin
                if (v_cnt > i_limits.border_limit) begin
                    v_bf = 1'b1;
                end
            end else if (v_cnt > i_limits.bit_limit) begin
                v_bits = v_bits | (CODE_BITS'(1) << v_idx);
            end
            n_counts[v_cc] = '0;
        end else begin
            n_counts[v_cc] = v_cnt;
        end

        // Advance the raster position
        n_col_in_cell = v_cic;
        n_cell_col    = v_cc;
        n_row_in_cell = v_ric;
        n_cell_row    = v_cr;
        if (v_cic == CELL_W'(CELL_SIZE - 1)) begin
            n_col_in_cell = '0;
            if (v_cc == GRID_W'(GRID_CELLS - 1)) begin
                n_cell_col = '0;
                if (v_ric == CELL_W'(CELL_SIZE - 1)) begin
                    n_row_in_cell = '0;
                    n_cell_row    = v_cr + GRID_W'(1);
                end else begin
                    n_row_in_cell = v_ric + CELL_W'(1);
                end
            end else begin
                n_cell_col = v_cc + GRID_W'(1);
            end
        end else begin
            n_col_in_cell = v_cic + CELL_W'(1);
        end

        // Hand over the finished image and start afresh
        n_border_failed = v_bf;
        n_bits          = v_bits;
        n_done          = r_done;
        if (i_take) begin
            n_done.valid = 1'b0;
        end
        if (v_last) begin
            n_done.valid         = 1'b1;
            n_done.border_failed = v_bf;
            n_done.bits          = v_bits;
            n_col_in_cell        = '0;
            n_cell_col           = '0;
            n_row_in_cell        = '0;
            n_cell_row           = '0;
            n_border_failed      = 1'b0;
            n_bits               = '0;
            for (int i = 0; i < GRID_CELLS; i++) begin
                n_counts[i] = '0;
            end
        end
    end

    // Image state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_in_cell   <= '0;
            r_cell_col      <= '0;
            r_row_in_cell   <= '0;
            r_cell_row      <= '0;
            r_border_failed <= 1'b0;
            r_bits          <= '0;
            for (int i = 0; i < GRID_CELLS; i++) begin
                r_counts[i] <= '0;
            end
        end else if (i_accept) begin
            r_col_in_cell   <= n_col_in_cell;
            r_cell_col      <= n_cell_col;
            r_row_in_cell   <= n_row_in_cell;
            r_cell_row      <= n_cell_row;
            r_border_failed <= n_border_failed;
            r_bits          <= n_bits;
            for (int i = 0; i < GRID_CELLS; i++) begin
                r_counts[i] <= n_counts[i];
            end
        end
    end

    // Holding register for a finished image
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done.valid <= 1'b0;
        end else if (i_accept) begin
            r_done <= n_done;
        end else if (i_take) begin
            r_done.valid <= 1'b0;
        end
    end

    assign o_done = r_done;

endmodule

[rtl/mgd_orient.sv]
// Corner-pattern orientation check and the result register.
// Depends on mgd_pkg; takes a finished image from mgd_cell_accum.
`timescale 1ns / 1ps

module mgd_orient
    import mgd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_done       i_done,
    output logic        o_take,     // finished image moves into the result register
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata   // marker_found, rotation[1:0], code_bits[24:0],
                                    // fail_reason[1:0], zero fill
);

    logic        r_out_valid;
    logic [31:0] r_out_data;
    logic [31:0] n_out_data;

    // One set corner cell with its three neighbours clear
    function automatic logic corner_match(input logic [CODE_BITS-1:0] bits,
                                          input int r1, input int c1,
                                          input int ra, input int ca,
                                          input int rb, input int cb,
                                          input int rc, input int cc);
        corner_match = bits[IDX_W'(r1 * CODE_STRIDE + c1)]
                    && !bits[IDX_W'(ra * CODE_STRIDE + ca)]
                    && !bits[IDX_W'(rb * CODE_STRIDE + cb)]
                    && !bits[IDX_W'(rc * CODE_STRIDE + cc)];
    endfunction

    localparam int N = CELL_COUNT;

    // Border failure first, then the corner patterns tried in order, first match wins
    always_comb begin
        logic       v_found;
        logic [1:0] v_rot;
        logic [1:0] v_fail;

        v_found = 1'b0;
        v_rot   = 2'd0;
        v_fail  = FAIL_NONE;
        priority if (i_done.border_failed) begin
            v_fail = FAIL_BORDER;
        end else if (corner_match(i_done.bits, 0, 0, 0, 1, 1, 0, 1, 1)) begin
            v_found = 1'b1;
            v_rot   = 2'd0;
        end else if (corner_match(i_done.bits, N-1, 0, N-2, 0, N-1, 1, N-2, 1)) begin
            v_found = 1'b1;
            v_rot   = 2'd1;
        end else if (corner_match(i_done.bits, N-1, N-1, N-2, N-1,
                                  N-1, N-2, N-2, N-2)) begin
            v_found = 1'b1;
            v_rot   = 2'd2;
        end else if (corner_match(i_done.bits, 0, N-1, 0, N-2, 1, N-2, 1, N-1)) begin
            v_found = 1'b1;
            v_rot   = 2'd3;
        end else begin
            v_fail = FAIL_PATTERN;
        end
        n_out_data = {2'b00, v_fail, i_done.bits, v_rot, v_found};
    end

    assign o_take = i_done.valid && (!r_out_valid || i_m_tready);

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_take) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

[rtl/marker_grid_decode.sv]
// Top level of the marker grid decoder: configuration registers and stream glue.
// Depends on mgd_pkg, mgd_cell_accum and mgd_orient.
`timescale 1ns / 1ps

// The decoder takes one pixel transaction per clock on the slave stream while
// o_s_tready is high, in raster order over a square image of
// (CELL_COUNT+2)*CELL_SIZE pixels on a side, with tuser high on the first pixel
// of each image. Every pixel is folded into the count of its cell. After the last
// pixel is taken, the finished image waits in the holding register and then in
// the result register, and one result transaction appears on the master stream.
// o_s_tready falls only when both registers are occupied and the master side is
// stalled. Configuration writes are always accepted and should be made while no
// image is in progress.
module marker_grid_decode
    import mgd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Pixel stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // pixel, zero fill
    input  logic        i_s_tuser,   // frame_start
    // Result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // marker_found, rotation[1:0], code_bits[24:0],
                                     // fail_reason[1:0], zero fill
    // Configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [6:0]  i_cfg_data
);

    t_limits r_limits;
    t_done   w_done;
    logic    w_take;
    logic    w_accept;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limits.border_limit <= BORDER_LIMIT_RST;
            r_limits.bit_limit    <= BIT_LIMIT_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_BORDER_LIMIT: r_limits.border_limit <= i_cfg_data;
                REG_BIT_LIMIT:    r_limits.bit_limit    <= i_cfg_data;
                default:          ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // Pixel transaction handshake
    assign o_s_tready = !w_done.valid || w_take;
    assign w_accept   = i_s_tvalid && o_s_tready;

    mgd_cell_accum u_accum (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_pixel       (i_s_tdata[0]),
        .i_frame_start (i_s_tuser),
        .i_limits      (r_limits),
        .i_take        (w_take),
        .o_done        (w_done)
    );

    mgd_orient u_orient (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_done     (w_done),
        .o_take     (w_take),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

endmodule

[test/mgd_checker.sv]
// Watches the pixel, result and configuration channels of marker_grid_decode.
// It tracks the cell tallies, decodes each finished image and compares results.
// Depends on mgd_pkg for geometry, register indexes and failure codes.
`timescale 1ns / 1ps

module mgd_checker
    import mgd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,   // pixel, zero fill
    input  logic        i_s_tuser,   // frame_start
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [31:0] i_m_tdata,   // marker_found, rotation[1:0], code_bits[24:0],
                                     // fail_reason[1:0], zero fill
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [6:0]  i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);

    localparam int SIDE       = GRID_CELLS * CELL_SIZE;
    localparam int SHOW_LIMIT = 10;

    // Index of the corner pattern that matched
    typedef enum logic [1:0] {
        ROT_TOP_LEFT,
        ROT_BOTTOM_LEFT,
        ROT_BOTTOM_RIGHT,
        ROT_TOP_RIGHT
    } t_rotation;

    typedef struct packed {
        logic                 found;
        logic [1:0]           rotation;
        logic [CODE_BITS-1:0] code;
        logic [1:0]           reason;
    } t_marker;

    // Mirror of the decoder state
    logic [6:0]           pix_col;
    logic [6:0]           pix_row;
    logic [COUNT_W-1:0]   cell_tally [GRID_CELLS];
    logic                 border_bad;
    logic [CODE_BITS-1:0] code_acc;
    logic [COUNT_W-1:0]   lim_border;
    logic [COUNT_W-1:0]   lim_bit;

    t_marker pending_markers [$];
    int      mismatches;

    function automatic void restart_image();
        pix_col    = '0;
        pix_row    = '0;
        border_bad = 1'b0;
        code_acc   = '0;
        foreach (cell_tally[k]) cell_tally[k] = '0;
    endfunction

    function automatic logic corner_is(logic [CODE_BITS-1:0] b, int r1, int c1,
                                       int ra, int ca, int rb, int cb, int rc, int cc);
        return b[r1*CODE_STRIDE + c1] && !b[ra*CODE_STRIDE + ca] &&
               !b[rb*CODE_STRIDE + cb] && !b[rc*CODE_STRIDE + cc];
    endfunction

    // Border verdict first, then the corner patterns in fixed order
    function automatic t_marker judge_grid(logic bad, logic [CODE_BITS-1:0] b);
        t_marker m;
        int      n;
        n          = CELL_COUNT;
        m.found    = 1'b1;
        m.rotation = ROT_TOP_LEFT;
        m.code     = b;
        m.reason   = FAIL_NONE;
        if (bad) begin
            m.found  = 1'b0;
            m.reason = FAIL_BORDER;
        end else if (corner_is(b, 0, 0, 0, 1, 1, 0, 1, 1)) begin
            m.rotation = ROT_TOP_LEFT;
        end else if (corner_is(b, n-1, 0, n-2, 0, n-1, 1, n-2, 1)) begin
            m.rotation = ROT_BOTTOM_LEFT;
        end else if (corner_is(b, n-1, n-1, n-2, n-1, n-1, n-2, n-2, n-2)) begin
            m.rotation = ROT_BOTTOM_RIGHT;
        end else if (corner_is(b, 0, n-1, 0, n-2, 1, n-2, 1, n-1)) begin
            m.rotation = ROT_TOP_RIGHT;
        end else begin
            m.found  = 1'b0;
            m.reason = FAIL_PATTERN;
        end
        return m;
    endfunction

    // One pixel transaction: tally, judge a finished cell, close the image
    function automatic void decode_pixel(logic px, logic fs);
        int cc;
        int cr;
        int idx;
        if (fs) restart_image();
        cc = (int'(pix_col) / CELL_SIZE) % GRID_CELLS;
        cr = int'(pix_row) / CELL_SIZE;
        if (px && cell_tally[cc] < COUNT_MAX) cell_tally[cc] = cell_tally[cc] + COUNT_W'(1);
        if (int'(pix_row) % CELL_SIZE == CELL_SIZE - 1 &&
            int'(pix_col) % CELL_SIZE == CELL_SIZE - 1) begin
            if (cr == 0 || cr == GRID_CELLS - 1 || cc == 0 || cc == GRID_CELLS - 1) begin
                if (cell_tally[cc] > lim_border) border_bad = 1'b1;
            end else if (cell_tally[cc] > lim_bit) begin
                idx = (cr - 1) * CODE_STRIDE + (cc - 1);
                if (idx < CODE_BITS) code_acc[idx] = 1'b1;
            end
            cell_tally[cc] = '0;
        end
        if (int'(pix_row) == SIDE - 1 && int'(pix_col) == SIDE - 1) begin
            pending_markers.insert(pending_markers.size(), judge_grid(border_bad, code_acc));
            restart_image();
        end else begin
            pix_col = pix_col + 7'(1);
            if (int'(pix_col) >= SIDE) begin
                pix_col = '0;
                pix_row = pix_row + 7'(1);
            end
        end
    endfunction

    function automatic void note_failure(string what, t_marker want, t_marker got);
        mismatches++;
        if (mismatches <= SHOW_LIMIT) begin
            $display("%t %s: exp found=%0d rot=%0d code=%07h reason=%0d",
                     $time, what, want.found, want.rotation, want.code, want.reason);
            $display("%t %s: got found=%0d rot=%0d code=%07h reason=%0d",
                     $time, what, got.found, got.rotation, got.code, got.reason);
        end
    endfunction

    always @(posedge i_clk) begin
        t_marker got;
        t_marker want;
        if (!i_rst_n) begin
            lim_border = BORDER_LIMIT_RST;
            lim_bit    = BIT_LIMIT_RST;
            restart_image();
            pending_markers.delete();
            mismatches = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == REG_BORDER_LIMIT) lim_border = i_cfg_data;
                else                                 lim_bit    = i_cfg_data;
            end
            // result transaction against the oldest expectation
            if (i_m_tvalid && i_m_tready) begin
                got.found    = i_m_tdata[0];
                got.rotation = i_m_tdata[2:1];
                got.code     = i_m_tdata[3 +: CODE_BITS];
                got.reason   = i_m_tdata[3 + CODE_BITS +: 2];
                if (pending_markers.size() == 0) begin
                    note_failure("unexpected result", '0, got);
                end else begin
                    want = pending_markers.pop_front();
                    if (got.found !== want.found || got.rotation !== want.rotation ||
                        got.code !== want.code || got.reason !== want.reason)
                        note_failure("result mismatch", want, got);
                end
            end
            if (i_s_tvalid && i_s_tready) decode_pixel(i_s_tdata[0], i_s_tuser);
        end
        o_fail_count <= mismatches;
        o_pending    <= pending_markers.size();
    end

endmodule

[test/tb_marker_grid_decode.sv]
// Top of the marker_grid_decode testbench: clock, reset, pixel and config stimulus.
// Checking is done by mgd_checker; depends on mgd_pkg and the decoder RTL.
`timescale 1ns / 1ps

module tb_marker_grid_decode;
    import mgd_pkg::*;

    localparam int SIDE        = GRID_CELLS * CELL_SIZE;
    localparam int AREA        = CELL_SIZE * CELL_SIZE;
    localparam int SPREAD      = 37;    // coprime with AREA, scatters set pixels in a cell
    localparam int HOLD_OFF    = 4;
    localparam int STALL_LIMIT = 2000;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata;
    logic        i_s_tuser;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [31:0] o_m_tdata;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_index;
    logic [6:0]  i_cfg_data;

    int         fail_count;
    int         pending;
    int         quiet_cycles;
    int         s_idle_pct;
    int         m_stall_pct;
    int         cell_plan [GRID_CELLS][GRID_CELLS];
    logic [6:0] plan_border;
    logic [6:0] plan_bit;
    logic       aligned;

    marker_grid_decode DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    mgd_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Result side back-pressure
    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(0, 99) >= m_stall_pct);
    end

    // Watchdog: cycles with no transaction on any channel
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic send_pixel(input logic px, input logic fs);
        while ($urandom_range(0, 99) < s_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {7'b0, px};
        i_s_tuser  <= fs;
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    // Streams the planned image in raster order; each cell gets its exact count
    task automatic send_image(input logic fs_first, input int n_pixels);
        int r;
        int c;
        int slot;
        int off;
        off = $urandom_range(0, AREA - 1);
        for (int k = 0; k < n_pixels; k++) begin
            r    = k / SIDE;
            c    = k % SIDE;
            slot = (r % CELL_SIZE) * CELL_SIZE + (c % CELL_SIZE);
            send_pixel(((slot * SPREAD + off) % AREA) < cell_plan[r/CELL_SIZE][c/CELL_SIZE],
                       fs_first && k == 0);
        end
    endtask

    // Sender pauses until every result is in, then lets the pipeline settle
    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (HOLD_OFF) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic idx, input logic [6:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic write_limits(input logic [6:0] border, input logic [6:0] bit_lim);
        wait_drained();
        cfg_write(REG_BORDER_LIMIT, border);
        cfg_write(REG_BIT_LIMIT, bit_lim);
        i_cfg_valid <= 1'b0;
        plan_border = border;
        plan_bit    = bit_lim;
    endtask

    function automatic int pick_low(int lim);
        if ($urandom_range(0, 3) == 0) return lim;
        return $urandom_range(0, lim);
    endfunction

    function automatic int pick_high(int lim);
        if (lim >= AREA) return AREA;
        if ($urandom_range(0, 3) == 0) return lim + 1;
        return $urandom_range(lim + 1, AREA);
    endfunction

    function automatic int pick_limit();
        int roll;
        roll = $urandom_range(0, 5);
        if (roll == 0) return 0;
        if (roll == 1) return AREA;
        return $urandom_range(0, AREA);
    endfunction

    function automatic void fill_plan(int count);
        foreach (cell_plan[r, c]) cell_plan[r][c] = count;
    endfunction

    // Cell counts for a code word, with n_bad border cell picks raised above the border limit, capped at AREA
    function automatic void plan_image(logic [CODE_BITS-1:0] code, int n_bad);
        int r;
        int c;
        foreach (cell_plan[pr, pc]) begin
            if (pr == 0 || pr == GRID_CELLS - 1 || pc == 0 || pc == GRID_CELLS - 1)
                cell_plan[pr][pc] = pick_low(int'(plan_border));
            else if (code[(pr - 1) * CODE_STRIDE + (pc - 1)])
                cell_plan[pr][pc] = pick_high(int'(plan_bit));
            else
                cell_plan[pr][pc] = pick_low(int'(plan_bit));
        end
        for (int k = 0; k < n_bad; k++) begin
            do begin
                r = $urandom_range(0, GRID_CELLS - 1);
                c = $urandom_range(0, GRID_CELLS - 1);
            end while (!(r == 0 || r == GRID_CELLS - 1 || c == 0 || c == GRID_CELLS - 1));
            cell_plan[r][c] = pick_high(int'(plan_border));
        end
    endfunction

    // Forces the orientation mark into one corner of the code grid
    function automatic logic [CODE_BITS-1:0] make_corner(logic [CODE_BITS-1:0] code,
                                                         logic bottom, logic right);
        int r0;
        int c0;
        int r1;
        int c1;
        r0 = bottom ? CELL_COUNT - 1 : 0;
        c0 = right  ? CELL_COUNT - 1 : 0;
        r1 = bottom ? r0 - 1 : r0 + 1;
        c1 = right  ? c0 - 1 : c0 + 1;
        code[r0 * CODE_STRIDE + c0] = 1'b1;
        code[r1 * CODE_STRIDE + c0] = 1'b0;
        code[r0 * CODE_STRIDE + c1] = 1'b0;
        code[r1 * CODE_STRIDE + c1] = 1'b0;
        return code;
    endfunction

    // Well-formed image with random content, now and then a flat one
    task automatic random_image();
        logic [CODE_BITS-1:0] code;
        int                   roll;
        roll = $urandom_range(0, 19);
        code = CODE_BITS'($urandom);
        if (roll == 0) begin
            fill_plan(0);
        end else if (roll == 1) begin
            fill_plan(AREA);
        end else begin
            if ($urandom_range(0, 2) != 0)
                code = make_corner(code, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            plan_image(code, ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0);
        end
        send_image(aligned ? logic'($urandom_range(0, 1)) : 1'b1, SIDE * SIDE);
        aligned = 1'b1;
    endtask

    // Broken sequences: a cut-off image or a burst of loose pixels
    task automatic broken_image();
        int n;
        if ($urandom_range(0, 1) == 0) begin
            plan_image(CODE_BITS'($urandom), 0);
            send_image(aligned ? logic'($urandom_range(0, 1)) : 1'b1,
                       $urandom_range(1, SIDE * SIDE - 1));
        end else begin
            n = $urandom_range(1, 120);
            for (int k = 0; k < n; k++)
                send_pixel(1'($urandom_range(0, 1)), $urandom_range(0, 9) == 0);
        end
        aligned = 1'b0;
    endtask

    task automatic run_phase(input int s_idle, input int m_stall, input int images);
        s_idle_pct  = s_idle;
        m_stall_pct = m_stall;
        for (int i = 0; i < images; i++) begin
            if (i % 5 == 0) write_limits(7'(pick_limit()), 7'(pick_limit()));
            if ($urandom_range(0, 5) == 0) broken_image();
            random_image();
        end
    endtask

    initial begin
        i_rst_n      <= 1'b0;
        i_s_tvalid   <= 1'b0;
        i_s_tdata    <= '0;
        i_s_tuser    <= 1'b0;
        i_m_tready   <= 1'b0;
        i_cfg_valid  <= 1'b0;
        i_cfg_index  <= REG_BORDER_LIMIT;
        i_cfg_data   <= '0;
        quiet_cycles <= 0;
        s_idle_pct   = 12;
        m_stall_pct  = 71;
        plan_border  = BORDER_LIMIT_RST;
        plan_bit     = BIT_LIMIT_RST;
        aligned      = 1'b1;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: each corner, back-to-back images with and without the frame flag
        plan_image(make_corner('0, 1'b0, 1'b0), 0);
        send_image(1'b1, SIDE * SIDE);
        plan_image(make_corner('0, 1'b1, 1'b0), 0);
        send_image(1'b0, SIDE * SIDE);
        plan_image(make_corner(CODE_BITS'($urandom), 1'b1, 1'b1), 0);
        send_image(1'b0, SIDE * SIDE);
        plan_image(make_corner(CODE_BITS'($urandom), 1'b0, 1'b1), 0);
        send_image(1'b1, SIDE * SIDE);
        // no corner pattern; all-ones code has no zeros around a corner
        plan_image('0, 0);
        send_image(1'b0, SIDE * SIDE);
        plan_image('1, 0);
        send_image(1'b0, SIDE * SIDE);
        // white border, alone and together with a good corner
        fill_plan(AREA);
        send_image(1'b0, SIDE * SIDE);
        plan_image(make_corner('0, 1'b0, 1'b0), 1);
        send_image(1'b1, SIDE * SIDE);
        wait_drained();
        // frame start mid-image, also on what would have been the last pixel
        plan_image(CODE_BITS'($urandom), 0);
        send_image(1'b1, 2345);
        plan_image(make_corner(CODE_BITS'($urandom), 1'b1, 1'b0), 0);
        send_image(1'b1, SIDE * SIDE);
        plan_image(CODE_BITS'($urandom), 0);
        send_image(1'b0, SIDE * SIDE - 1);
        plan_image(make_corner(CODE_BITS'($urandom), 1'b0, 1'b1), 0);
        send_image(1'b1, SIDE * SIDE);
        // limit extremes
        write_limits(7'(AREA), 7'(AREA));
        fill_plan(AREA);
        send_image(1'b1, SIDE * SIDE);
        write_limits(7'(0), 7'(0));
        fill_plan(0);
        send_image(1'b1, SIDE * SIDE);
        plan_image(make_corner(CODE_BITS'($urandom), 1'b1, 1'b1), 0);
        send_image(1'b0, SIDE * SIDE);
        write_limits(7'(0), 7'(AREA));
        plan_image(CODE_BITS'($urandom), 0);
        send_image(1'b1, SIDE * SIDE);
        write_limits(7'(AREA), 7'(0));
        plan_image(make_corner(CODE_BITS'($urandom), 1'b0, 1'b0), 2);
        send_image(1'b1, SIDE * SIDE);

        // Random part, three idling profiles
        run_phase(12, 71, 14);
        run_phase(71, 12, 8);
        run_phase(0, 0, 14);

        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (10) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

[filelist.f]
rtl/mgd_pkg.sv
rtl/mgd_cell_accum.sv
rtl/mgd_orient.sv
rtl/marker_grid_decode.sv
test/mgd_checker.sv
test/tb_marker_grid_decode.sv
